@@ hw/rtl/fec_pkg.sv @@
package fec_pkg;

  // CRC-32 (reflected) and FNV-1a constants.
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  // Item kinds on the input channel.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Header bytes are klen, vlen low, vlen high and two zeros; the hash is four bytes.
  localparam logic [2:0] HDR_LAST  = 3'd4;
  localparam logic [2:0] HASH_LAST = 3'd3;

  // Byte source of the CRC unit.
  typedef enum logic [1:0] {
    SRC_HDR  = 2'd0,
    SRC_HASH = 2'd1,
    SRC_DATA = 2'd2,
    SRC_KEY  = 2'd3
  } crc_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start_load;
    logic       crc_en;
    crc_src_t   crc_src;
    logic [2:0] byte_idx;
    logic       key_write;
    logic       rem_dec;
    logic       rem_load_key;
    logic       rem_load_val;
    logic       rd_run;
    logic       out_load;
  } fec_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic klen_zero;
    logic vlen_zero;
    logic rem_one;
    logic rd_valid;
    logic rd_last;
    logic out_free;
  } fec_sts_t;

  // One byte step of the reflected CRC-32.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/fec_in_if.sv @@
interface fec_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  key_length;
  logic [15:0] value_length;
  logic [7:0]  data_byte;

  modport source (output valid, kind, key_length, value_length, data_byte, input ready);
  modport sink (input valid, kind, key_length, value_length, data_byte, output ready);
endinterface

@@ hw/rtl/fec_out_if.sv @@
interface fec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rec_hash;
  logic [31:0] entry_crc;

  modport source (output valid, rec_hash, entry_crc, input ready);
  modport sink (input valid, rec_hash, entry_crc, output ready);
endinterface

@@ hw/rtl/flash_entry_checksum.sv @@
// Check-word builder for one flash key-value record.
// The item channel carries a start transfer (kind 0) with the key and value
// lengths, then one transfer per key byte and per value byte (kind 1). The
// result channel gives one transfer per record: the FNV-1a key hash and the
// CRC-32 over the lengths, the hash, the key and the value.
// A start transfer is followed by the header steps, in which the five header
// bytes enter the CRC; key bytes are then taken one per cycle. After the
// last key byte the four hash bytes enter the CRC and the buffered key is
// read back from the key RAM at one byte per cycle; value bytes are then
// taken one per cycle. The result is loaded in the emit state, once the
// output register is free, after the last byte is folded in.
// Data transfers outside an open record are dropped; a start transfer in an
// open record restarts it with no result for the old one.
// The result sits in an output register, so new items are taken while it
// waits; if a second result is ready before the first is taken, the block
// holds it and stops taking items until the receiver frees the register.
// Reset returns the block to idle and empties the output register.
module flash_entry_checksum
  import fec_pkg::*;
#(
  parameter int KEY_STORE_DEPTH = 256
) (
  input logic      clk,
  input logic      rst,
  fec_in_if.sink   item,
  fec_out_if.source result
);

  fec_cmd_t cmd;
  fec_sts_t sts;

  fec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (item.kind),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fec_dp #(
    .KEY_STORE_DEPTH (KEY_STORE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .key_length   (item.key_length),
    .value_length (item.value_length),
    .data_byte    (item.data_byte),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_hash     (result.rec_hash),
    .out_crc      (result.entry_crc)
  );

endmodule

@@ hw/rtl/fec_ram.sv @@
module fec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/fec_dp.sv @@
module fec_dp
  import fec_pkg::*;
#(
  parameter int KEY_STORE_DEPTH = 256,
  localparam int AW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  fec_cmd_t    cmd,
  output fec_sts_t    sts,
  input  logic [7:0]  key_length,
  input  logic [15:0] value_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash,
  output logic [31:0] out_crc
);

  localparam logic [8:0] DEPTH_LIMIT = 9'(KEY_STORE_DEPTH);

  logic [7:0]  klen;
  logic [15:0] vlen;
  logic [15:0] rem;
  logic [31:0] hash;
  logic [31:0] crc;
  logic [7:0]  wpos;
  logic [7:0]  rcnt;
  logic [7:0]  ccnt;
  logic        rd_pend;
  logic        rd_issue;
  logic [7:0]  klen_clamped;
  logic [7:0]  crc_in;
  logic [31:0] crc_next;
  logic [31:0] hash_next;
  logic [7:0]  ram_rdata;

  // Key lengths beyond the store are cut to its depth.
  assign klen_clamped = ({1'b0, key_length} > DEPTH_LIMIT) ? DEPTH_LIMIT[7:0] : key_length;

  // Byte fed to the CRC unit.
  always_comb begin
    crc_in = 8'h00;
    case (cmd.crc_src)
      SRC_HDR: begin
        case (cmd.byte_idx)
          3'd0:    crc_in = klen;
          3'd1:    crc_in = vlen[7:0];
          3'd2:    crc_in = vlen[15:8];
          default: crc_in = 8'h00;
        endcase
      end
      SRC_HASH: begin
        case (cmd.byte_idx[1:0])
          2'd0:    crc_in = hash[7:0];
          2'd1:    crc_in = hash[15:8];
          2'd2:    crc_in = hash[23:16];
          default: crc_in = hash[31:24];
        endcase
      end
      SRC_DATA: crc_in = data_byte;
      default:  crc_in = ram_rdata;
    endcase
  end

  assign crc_next  = crc_byte(crc, crc_in);
  assign hash_next = (hash ^ {24'h0, data_byte}) * FNV_PRIME;

  // A key buffer read is issued while reads remain.
  assign rd_issue = cmd.rd_run && (rcnt < klen);

  fec_ram #(
    .WIDTH (8),
    .DEPTH (KEY_STORE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.key_write),
    .waddr (wpos[AW-1:0]),
    .wdata (data_byte),
    .raddr (rcnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Control flags: result slot and read pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= cmd.start_load ? 1'b0 : rd_issue;
    end
  end

  // Record registers, accumulators and counters.
  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      klen <= klen_clamped;
      vlen <= value_length;
      hash <= FNV_BASIS;
      crc  <= CRC_ONES;
      wpos <= 8'd0;
      rcnt <= 8'd0;
      ccnt <= 8'd0;
    end else begin
      if (cmd.crc_en) begin
        crc <= crc_next;
      end
      if (cmd.key_write) begin
        hash <= hash_next;
        wpos <= wpos + 8'd1;
      end
      if (rd_issue) begin
        rcnt <= rcnt + 8'd1;
      end
      if (cmd.rd_run && rd_pend) begin
        ccnt <= ccnt + 8'd1;
      end
    end
    if (cmd.rem_load_key) begin
      rem <= {8'h00, klen};
    end else if (cmd.rem_load_val) begin
      rem <= vlen;
    end else if (cmd.rem_dec) begin
      rem <= rem - 16'd1;
    end
    if (cmd.out_load) begin
      out_hash <= hash;
      out_crc  <= crc ^ CRC_ONES;
    end
  end

  assign sts.klen_zero = (klen == 8'd0);
  assign sts.vlen_zero = (vlen == 16'd0);
  assign sts.rem_one   = (rem == 16'd1);
  assign sts.rd_valid  = rd_pend;
  assign sts.rd_last   = rd_pend && ((ccnt + 8'd1) == klen);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

@@ hw/rtl/fec_ctrl.sv @@
module fec_ctrl
  import fec_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_ready,
  input  fec_sts_t sts,
  output fec_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_HDR  = 7'b0000010,
    ST_KEY  = 7'b0000100,
    ST_HASH = 7'b0001000,
    ST_KRD  = 7'b0010000,
    ST_VAL  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] step;
  logic [2:0] step_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE) || (state == ST_KEY) || (state == ST_VAL);
  assign accept   = in_valid && in_ready;

  // Sequencing of one record.
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.crc_src = SRC_HDR;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_kind == KIND_START) begin
          cmd.start_load = 1'b1;
          step_next      = 3'd0;
          state_next     = ST_HDR;
        end
      end
      ST_HDR: begin
        cmd.crc_en   = 1'b1;
        cmd.crc_src  = SRC_HDR;
        cmd.byte_idx = step;
        step_next    = step + 3'd1;
        if (step == HDR_LAST) begin
          step_next = 3'd0;
          if (sts.klen_zero) begin
            state_next = ST_HASH;
          end else begin
            cmd.rem_load_key = 1'b1;
            state_next       = ST_KEY;
          end
        end
      end
      ST_KEY: begin
        if (accept && in_kind == KIND_START) begin
          cmd.start_load = 1'b1;
          step_next      = 3'd0;
          state_next     = ST_HDR;
        end else if (accept) begin
          cmd.key_write = 1'b1;
          cmd.rem_dec   = 1'b1;
          if (sts.rem_one) begin
            step_next  = 3'd0;
            state_next = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        cmd.crc_en   = 1'b1;
        cmd.crc_src  = SRC_HASH;
        cmd.byte_idx = step;
        step_next    = step + 3'd1;
        if (step == HASH_LAST) begin
          step_next = 3'd0;
          if (!sts.klen_zero) begin
            state_next = ST_KRD;
          end else if (sts.vlen_zero) begin
            state_next = ST_EMIT;
          end else begin
            cmd.rem_load_val = 1'b1;
            state_next       = ST_VAL;
          end
        end
      end
      ST_KRD: begin
        // Every key byte read back from the buffer enters the CRC.
        cmd.rd_run  = 1'b1;
        cmd.crc_src = SRC_KEY;
        cmd.crc_en  = sts.rd_valid;
        if (sts.rd_last) begin
          if (sts.vlen_zero) begin
            state_next = ST_EMIT;
          end else begin
            cmd.rem_load_val = 1'b1;
            state_next       = ST_VAL;
          end
        end
      end
      ST_VAL: begin
        if (accept && in_kind == KIND_START) begin
          cmd.start_load = 1'b1;
          step_next      = 3'd0;
          state_next     = ST_HDR;
        end else if (accept) begin
          cmd.crc_en  = 1'b1;
          cmd.crc_src = SRC_DATA;
          cmd.rem_dec = 1'b1;
          if (sts.rem_one) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= 3'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

@@ hw/rtl/fec_checker.sv @@
module fec_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_kind,
  input logic out_valid,
  input logic out_ready
);

  // The result slot is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A pending result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // A start transfer is followed by header work, so no item is taken next.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_kind |=> !in_ready)
    else $error("item taken during header steps");

  // A new result only appears right after the item channel was not ready.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while taking items");

endmodule

bind flash_entry_checksum fec_checker u_fec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_kind   (item.kind),
  .out_valid (result.valid),
  .out_ready (result.ready)
);

@@ tb/flash_entry_checksum_tb.sv @@
`timescale 1ns / 1ps

module flash_entry_checksum_tb;
  import fec_pkg::*;

  localparam int KEY_DEPTH = 256;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 2 * KEY_DEPTH + 64;
  localparam int RANDOM_ITEMS = 1000;

  typedef enum logic [1:0] {
    REC_IDLE  = 2'd0,
    REC_KEY   = 2'd1,
    REC_VALUE = 2'd2
  } rec_phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  key_length;
    logic [15:0] value_length;
    logic [7:0]  data_byte;
  } rec_item_t;

  typedef struct packed {
    logic [31:0] rec_hash;
    logic [31:0] entry_crc;
  } check_words_t;

  logic clk;
  logic rst;

  fec_in_if item_ch ();
  fec_out_if result_ch ();

  flash_entry_checksum #(
    .KEY_STORE_DEPTH(KEY_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch)
  );

  // Items waiting to be driven, and check words waiting to come out.
  rec_item_t item_queue[$];
  check_words_t expected_words[$];

  // Shadow copy of the record state.
  logic [7:0] shadow_key[KEY_DEPTH];
  logic [31:0] shadow_hash;
  logic [31:0] shadow_crc;
  logic [8:0] shadow_key_len;
  logic [8:0] shadow_key_pos;
  logic [15:0] shadow_value_len;
  logic [15:0] shadow_remaining;
  rec_phase_t shadow_phase;

  // Run statistics and handshake bookkeeping.
  int errors;
  int results_seen;
  int items_taken;
  int items_queued;
  int strays_dropped;
  int records_dropped;
  int held_input_cycles;
  int longest_key;
  int longest_value;
  bit in_fire;
  int burst_left;
  int gap_left;
  int holdoff_asks;
  int holdoff_served;
  int holdoff_left;
  logic [15:0] stall_pattern;
  int pattern_step;

  always #5 clk = ~clk;

  // One byte step of the reflected CRC, folded in bit by bit.
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // A 32-bit word enters the CRC low byte first.
  function automatic logic [31:0] crc_fold_word(input logic [31:0] c, input logic [31:0] w);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 4; i++) begin
      r = crc_fold_byte(r, w[8*i +: 8]);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  // The record is complete: queue its check words and close it.
  task automatic emit_words();
    check_words_t words;
    words.rec_hash = shadow_hash;
    words.entry_crc = shadow_crc ^ CRC_ONES;
    expected_words.push_back(words);
    if (shadow_key_len > longest_key) longest_key = shadow_key_len;
    if (shadow_value_len > longest_value) longest_value = shadow_value_len;
    shadow_phase = REC_IDLE;
    shadow_remaining = '0;
  endtask

  // The key is complete: the hash, then the buffered key, enter the CRC.
  task automatic close_key();
    shadow_crc = crc_fold_word(shadow_crc, shadow_hash);
    for (int i = 0; i < shadow_key_len; i++) begin
      shadow_crc = crc_fold_byte(shadow_crc, shadow_key[i]);
    end
    if (shadow_value_len == 0) begin
      emit_words();
    end else begin
      shadow_phase = REC_VALUE;
      shadow_remaining = shadow_value_len;
    end
  endtask

  // Advance the shadow state by one accepted item.
  task automatic fold_item(input rec_item_t it);
    logic [8:0] klen;
    if (it.kind == KIND_START) begin
      if (shadow_phase != REC_IDLE) records_dropped++;
      klen = (it.key_length > KEY_DEPTH) ? 9'(KEY_DEPTH) : {1'b0, it.key_length};
      shadow_key_len = klen;
      shadow_value_len = it.value_length;
      shadow_key_pos = '0;
      shadow_hash = FNV_BASIS;
      shadow_crc = crc_fold_byte(CRC_ONES, klen[7:0]);
      shadow_crc = crc_fold_word(shadow_crc, {16'h0, it.value_length});
      if (klen == 0) begin
        close_key();
      end else begin
        shadow_phase = REC_KEY;
        shadow_remaining = 16'(klen);
      end
    end else begin
      case (shadow_phase)
        REC_KEY: begin
          if (shadow_key_pos < KEY_DEPTH) shadow_key[shadow_key_pos] = it.data_byte;
          shadow_key_pos++;
          shadow_hash = (shadow_hash ^ {24'h0, it.data_byte}) * FNV_PRIME;
          shadow_remaining--;
          if (shadow_remaining == 0) close_key();
        end
        REC_VALUE: begin
          shadow_crc = crc_fold_byte(shadow_crc, it.data_byte);
          shadow_remaining--;
          if (shadow_remaining == 0) emit_words();
        end
        default: begin
          strays_dropped++;
        end
      endcase
    end
  endtask

  task automatic check_words(input logic [31:0] hash, input logic [31:0] crc);
    check_words_t want;
    results_seen++;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("result hash %h crc %h with nothing expected", hash, crc));
      return;
    end
    want = expected_words.pop_front();
    if (hash !== want.rec_hash) begin
      report_mismatch($sformatf("rec_hash got %h, expected %h", hash, want.rec_hash));
    end
    if (crc !== want.entry_crc) begin
      report_mismatch($sformatf("entry_crc got %h, expected %h", crc, want.entry_crc));
    end
  endtask

  // Stimulus helpers; the unused fields of each item carry random noise.
  task automatic push_start(input int klen, input int vlen);
    rec_item_t it;
    it.kind = KIND_START;
    it.key_length = 8'(klen);
    it.value_length = 16'(vlen);
    it.data_byte = 8'($urandom);
    item_queue.push_back(it);
  endtask

  task automatic push_byte(input logic [7:0] b);
    rec_item_t it;
    it.kind = KIND_DATA;
    it.key_length = 8'($urandom);
    it.value_length = 16'($urandom);
    it.data_byte = b;
    item_queue.push_back(it);
  endtask

  // A record with random content; a cut below the full size leaves it open.
  task automatic push_record(input int klen, input int vlen, input int cut);
    int n;
    n = klen + vlen;
    if (cut >= 0 && cut < n) n = cut;
    push_start(klen, vlen);
    repeat (n) push_byte(8'($urandom));
    items_queued += 1 + n;
  endtask

  // Monitor: check results and predict from accepted items at the rising edge.
  always @(posedge clk) begin
    rec_item_t seen;
    in_fire = 1'b0;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        check_words(result_ch.rec_hash, result_ch.entry_crc);
      end
      if (item_ch.valid && item_ch.ready) begin
        in_fire = 1'b1;
        items_taken++;
        seen.kind = item_ch.kind;
        seen.key_length = item_ch.key_length;
        seen.value_length = item_ch.value_length;
        seen.data_byte = item_ch.data_byte;
        fold_item(seen);
      end else if (item_ch.valid && holdoff_left > 0) begin
        held_input_cycles++;
      end
    end
  end

  // Driver: bursts of items from the queue, separated by random gaps.
  always @(negedge clk) begin
    rec_item_t next_item;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (item_ch.valid && !in_fire) begin
      // The offered item has not been taken yet; keep it steady.
    end else if (burst_left > 0 && item_queue.size() > 0) begin
      next_item = item_queue.pop_front();
      item_ch.valid <= 1'b1;
      item_ch.kind <= next_item.kind;
      item_ch.key_length <= next_item.key_length;
      item_ch.value_length <= next_item.value_length;
      item_ch.data_byte <= next_item.data_byte;
      burst_left--;
    end else begin
      item_ch.valid <= 1'b0;
      if (burst_left == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: a rotating stall pattern, or a long hold-off when one is asked for.
  always @(negedge clk) begin
    if (holdoff_asks != holdoff_served) begin
      holdoff_served = holdoff_asks;
      holdoff_left = HOLD_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      pattern_step++;
      if (pattern_step == 16) begin
        pattern_step = 0;
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom) | 16'h0001;
          2: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
          default: stall_pattern = 16'($urandom) | 16'h8001;
        endcase
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int klen;
    int vlen;
    int pick;
    bit paused;
    bit held;
    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.kind = KIND_START;
    item_ch.key_length = '0;
    item_ch.value_length = '0;
    item_ch.data_byte = '0;
    result_ch.ready = 1'b0;
    stall_pattern = 16'hFFFF;
    for (int i = 0; i < KEY_DEPTH; i++) shadow_key[i] = '0;
    shadow_hash = FNV_BASIS;
    shadow_crc = CRC_ONES;
    shadow_key_len = '0;
    shadow_key_pos = '0;
    shadow_value_len = '0;
    shadow_remaining = '0;
    shadow_phase = REC_IDLE;
    paused = 1'b0;
    held = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: a stray byte before any record.
    push_byte(8'hFF);
    // Empty record: the start item alone gives the result.
    push_start(0, 0);
    // Empty key, then empty value.
    push_start(0, 1);
    push_byte(8'h00);
    push_start(1, 0);
    push_byte(8'hFF);
    push_start(2, 2);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hAA);
    push_byte(8'h55);
    // Restart while the key is open, with the largest value length.
    push_start(3, 16'hFFFF);
    push_byte(8'h5A);
    push_start(1, 1);
    push_byte(8'h80);
    push_byte(8'h01);
    // A stray byte after a closed record.
    push_byte(8'h7E);
    // Restart while the value is open, and right after the longest key length.
    push_start(1, 3);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    push_start(255, 16'h8000);
    push_start(0, 0);

    // Random part: mostly well-formed records, some cut short, some noise.
    while (items_queued < RANDOM_ITEMS) begin
      if (!paused && items_queued > RANDOM_ITEMS / 3) begin
        // The sender stops until every result is back.
        paused = 1'b1;
        wait (item_queue.size() == 0 && item_ch.valid === 1'b0 && expected_words.size() == 0);
        repeat (40) @(posedge clk);
      end
      if (!held && items_queued > 2 * RANDOM_ITEMS / 3) begin
        // The receiver holds off while empty records keep coming.
        held = 1'b1;
        wait (item_queue.size() == 0 && item_ch.valid === 1'b0);
        @(posedge clk);
        holdoff_asks++;
        repeat (24) push_record(0, 0, -1);
      end
      klen = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
      vlen = ($urandom_range(0, 29) == 0) ? $urandom_range(17, 300) : $urandom_range(0, 16);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        push_record(klen, vlen, -1);
      end else if (pick < 90) begin
        push_record(klen, vlen, $urandom_range(0, klen + vlen));
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end
    end
    // A record with the longest key closes the stimulus.
    push_record(255, 8, -1);

    wait (item_queue.size() == 0 && item_ch.valid === 1'b0 && expected_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run summary: %0d input transfers, %0d results, %0d records dropped by restart,",
             items_taken, results_seen, records_dropped);
    $display("Run summary: %0d stray bytes ignored, longest key %0d, longest value %0d,",
             strays_dropped, longest_key, longest_value);
    $display("Run summary: input held back %0d cycles.", held_input_cycles);
    if (errors == 0) begin
      $display("[flash_entry_checksum] OK");
    end else begin
      $display("[flash_entry_checksum] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(20_000_000);
    $display("[flash_entry_checksum] ERROR");
    $finish;
  end

endmodule
